>>> hw/rtl/ttc_aeb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_aeb_pkg: shared types and constants of the emergency brake block
// State codes, register indexes and the cosine polynomial coefficients.
// ----------------------------------------------------------------------------
package ttc_aeb_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_HORNER,
    ST_SCALE,
    ST_CHECK,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  localparam logic [1:0] CFG_START_ANGLE     = 2'd0;
  localparam logic [1:0] CFG_ANGLE_STEP      = 2'd1;
  localparam logic [1:0] CFG_BRAKE_THRESHOLD = 2'd2;
  localparam logic [1:0] CFG_NO_THREAT_TIME  = 2'd3;

  localparam int unsigned DIV_STEPS = 20;

  localparam logic [16:0] COS_ONE     = 17'h10000;
  localparam logic [16:0] HORNER_INIT = 17'd60;

  typedef logic [16:0] coef_t [4];
  localparam coef_t HORNER_C = '{17'd1367, 17'd16625, 17'd80852, 17'd65536};

  localparam logic [19:0] MIN_INIT        = 20'hFFFFF;
  localparam logic [19:0] THRESHOLD_RESET = 20'd384;
  localparam logic [19:0] NO_THREAT_RESET = 20'd768000;

endpackage

>>> hw/rtl/ttc_emergency_brake.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_emergency_brake: time to collision emergency braking
// Forms closing speed per lidar beam, divides range by it bit serially,
// keeps the scan minimum and reports it with a brake flag on the last beam.
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata, tuser (opcode), tlast
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata (brake, min_ttc)
// cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// A speed word is stored without leaving the idle state. A beam word passes
// the square, Horner, scale and check states, then the restoring divider that
// produces one quotient bit per cycle; an invalid or saturated beam skips it.
// Reset is synchronous; no clearing pass is needed. A last beam waits in the
// final state while the previous result still sits in the output register.
// ----------------------------------------------------------------------------
module ttc_emergency_brake #(
  parameter int COS_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: speed_value[15:0], range_value[31:16], range_invalid[32].
  input  logic [39:0] s_axis_tdata,
  // Fields from bit 0: opcode[0].
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: brake[0], min_ttc[20:1].
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  localparam logic [15:0] ANG_MASK = 16'hFFFF << (16 - COS_TABLE_BITS);

  ttc_aeb_pkg::state_t state, state_next;

  logic [15:0] start_angle;
  logic [15:0] angle_step;
  logic [19:0] brake_threshold;
  logic [19:0] no_threat_time;

  logic [15:0] stored_speed;
  logic [15:0] current_angle;
  logic [19:0] running_min;
  logic        first_beam;

  logic [15:0] range_q;
  logic        invalid_q;
  logic        last_q;
  logic [16:0] y;
  logic        neg;
  logic [15:0] x2;
  logic [16:0] p;
  logic [1:0]  hstep;
  logic signed [33:0] prod;
  logic [31:0] divisor;
  logic [31:0] rem;
  logic [19:0] quo;
  logic [4:0]  cnt;
  logic        sat;

  logic        out_valid;
  logic        out_brake;
  logic [19:0] out_min;

  logic        in_accept;
  logic        beam_accept;
  logic        out_load;

  logic [15:0] beam_angle;
  logic [15:0] qangle;
  logic [15:0] xq;
  logic [31:0] sq;
  logic [32:0] hprod;
  logic [17:0] hdiff;
  logic [16:0] hnext;
  logic [16:0] mag;
  logic signed [17:0] cosv;
  logic [31:0] dividend_top;
  logic        closing_pos;
  logic [32:0] rem2;
  logic [19:0] tval;
  logic [19:0] new_min;

  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_min, out_brake};

  assign beam_angle = first_beam ? start_angle : current_angle;
  assign qangle     = beam_angle & ANG_MASK;
  assign xq         = {qangle[13:0], 2'b00};

  assign sq    = y[15:0] * y[15:0];
  assign hprod = p * x2;
  assign hdiff = {1'b0, ttc_aeb_pkg::HORNER_C[hstep]} - {1'b0, hprod[32:16]};
  assign hnext = ((hstep == 2'd3) &&
                  (hdiff[17] || (hdiff[16:0] > ttc_aeb_pkg::COS_ONE))) ?
                 ttc_aeb_pkg::COS_ONE : hdiff[16:0];
  assign mag   = y[16] ? 17'd0 : p;
  assign cosv  = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  assign dividend_top = {12'd0, range_q, 4'd0};
  assign closing_pos  = !prod[33] && (prod != 34'sd0);
  assign rem2         = {rem, 1'b0};

  assign tval    = (sat || (quo >= no_threat_time)) ? no_threat_time : quo;
  assign new_min = (tval < running_min) ? tval : running_min;

  always_comb begin
    state_next = state;
    unique case (state)
      ttc_aeb_pkg::ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tuser) state_next = ttc_aeb_pkg::ST_SQUARE;
      end
      ttc_aeb_pkg::ST_SQUARE: state_next = ttc_aeb_pkg::ST_HORNER;
      ttc_aeb_pkg::ST_HORNER: begin
        if (hstep == 2'd3) state_next = ttc_aeb_pkg::ST_SCALE;
      end
      ttc_aeb_pkg::ST_SCALE: state_next = ttc_aeb_pkg::ST_CHECK;
      ttc_aeb_pkg::ST_CHECK: begin
        if (invalid_q || !closing_pos || (dividend_top >= prod[31:0])) begin
          state_next = ttc_aeb_pkg::ST_FINISH;
        end else begin
          state_next = ttc_aeb_pkg::ST_DIVIDE;
        end
      end
      ttc_aeb_pkg::ST_DIVIDE: begin
        if (cnt == 5'(ttc_aeb_pkg::DIV_STEPS - 1)) state_next = ttc_aeb_pkg::ST_FINISH;
      end
      ttc_aeb_pkg::ST_FINISH: begin
        if (!last_q || !out_valid || m_axis_tready) state_next = ttc_aeb_pkg::ST_IDLE;
      end
      default: state_next = ttc_aeb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ttc_aeb_pkg::ST_IDLE);
    in_accept     = s_axis_tvalid && s_axis_tready;
    beam_accept   = in_accept && s_axis_tuser;
    out_load      = (state == ttc_aeb_pkg::ST_FINISH) && last_q &&
                    (!out_valid || m_axis_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttc_aeb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle     <= '0;
      angle_step      <= '0;
      brake_threshold <= ttc_aeb_pkg::THRESHOLD_RESET;
      no_threat_time  <= ttc_aeb_pkg::NO_THREAT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ttc_aeb_pkg::CFG_START_ANGLE:     start_angle     <= cfg_data[15:0];
        ttc_aeb_pkg::CFG_ANGLE_STEP:      angle_step      <= cfg_data[15:0];
        ttc_aeb_pkg::CFG_BRAKE_THRESHOLD: brake_threshold <= cfg_data;
        ttc_aeb_pkg::CFG_NO_THREAT_TIME:  no_threat_time  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_speed  <= '0;
      current_angle <= '0;
      running_min   <= ttc_aeb_pkg::MIN_INIT;
      first_beam    <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      if (in_accept && !s_axis_tuser) stored_speed <= s_axis_tdata[15:0];
      if (beam_accept) begin
        current_angle <= beam_angle + angle_step;
        first_beam    <= 1'b0;
      end
      if (state == ttc_aeb_pkg::ST_FINISH && !last_q) running_min <= new_min;
      if (out_load) begin
        running_min <= ttc_aeb_pkg::MIN_INIT;
        first_beam  <= 1'b1;
        out_valid   <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beam_accept) begin
      range_q   <= s_axis_tdata[31:16];
      invalid_q <= s_axis_tdata[32];
      last_q    <= s_axis_tlast;
      neg       <= qangle[15] ^ qangle[14];
      y         <= qangle[14] ? (ttc_aeb_pkg::COS_ONE - {1'b0, xq}) : {1'b0, xq};
    end
    unique case (state)
      ttc_aeb_pkg::ST_SQUARE: begin
        x2    <= sq[31:16];
        p     <= ttc_aeb_pkg::HORNER_INIT;
        hstep <= 2'd0;
      end
      ttc_aeb_pkg::ST_HORNER: begin
        p     <= hnext;
        hstep <= hstep + 2'd1;
      end
      ttc_aeb_pkg::ST_SCALE: begin
        prod <= $signed(stored_speed) * cosv;
      end
      ttc_aeb_pkg::ST_CHECK: begin
        sat     <= invalid_q || !closing_pos || (dividend_top >= prod[31:0]);
        divisor <= prod[31:0];
        rem     <= dividend_top;
        quo     <= '0;
        cnt     <= '0;
      end
      ttc_aeb_pkg::ST_DIVIDE: begin
        if (rem2 >= {1'b0, divisor}) begin
          rem <= 32'(rem2 - {1'b0, divisor});
          quo <= {quo[18:0], 1'b1};
        end else begin
          rem <= rem2[31:0];
          quo <= {quo[18:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
      end
      default: ;
    endcase
    if (out_load) begin
      out_min   <= new_min;
      out_brake <= (new_min < brake_threshold);
    end
  end

  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    (state == ttc_aeb_pkg::ST_DIVIDE) |-> (rem < divisor))
    else $error("divider remainder not below divisor");

  a_check_next: assert property (@(posedge clk) disable iff (rst)
    (state == ttc_aeb_pkg::ST_CHECK) |=>
    (state == ttc_aeb_pkg::ST_DIVIDE || state == ttc_aeb_pkg::ST_FINISH))
    else $error("unexpected state after range check");

  a_out_from_last: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && m_axis_tvalid && !$past(m_axis_tvalid)) |->
    $past(state == ttc_aeb_pkg::ST_FINISH && last_q))
    else $error("result word without a last beam");

  a_ready_busy: assert property (@(posedge clk) disable iff (rst)
    beam_accept |=> !s_axis_tready)
    else $error("input accepted while a beam is in progress");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the time to collision brake block
// Feeds speed and lidar beam words with random gaps and random output stalls.
// A scoreboard predicts the scan minimum and the brake flag of every finished
// scan and compares them with the result words. The registers are rewritten
// only while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TABLE_BITS    = 10;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 40;
  localparam bit OP_SPEED      = 1'b0;
  localparam bit OP_BEAM       = 1'b1;

  typedef struct packed {
    logic        brake;
    logic [19:0] min_ttc;
  } verdict_t;

  class ttc_tracker;
    logic [15:0] start_angle;
    logic [15:0] angle_step;
    logic [19:0] brake_threshold;
    logic [19:0] no_threat_time;
    logic [15:0] speed;
    logic [15:0] next_angle;
    logic [19:0] scan_min;
    bit          fresh_scan;
    verdict_t    verdicts_due[$];
    int          errors;

    function new();
      start_angle     = '0;
      angle_step      = '0;
      brake_threshold = 20'd384;
      no_threat_time  = 20'd768000;
      speed           = '0;
      next_angle      = '0;
      scan_min        = 20'hFFFFF;
      fresh_scan      = 1'b1;
      errors          = 0;
    endfunction

    function longint cos_mag(longint x);
      longint x2;
      longint p;
      if (x >= 65536) return 0;
      x2 = (x * x) >> 16;
      p = 60;
      p = 1367 - ((p * x2) >> 16);
      p = 16625 - ((p * x2) >> 16);
      p = 80852 - ((p * x2) >> 16);
      p = 65536 - ((p * x2) >> 16);
      if (p > 65536) p = 65536;
      return p;
    endfunction

    function longint cosine_q16(logic [15:0] angle);
      logic [15:0] a;
      longint      x;
      a = {angle[15:16-TABLE_BITS], {(16 - TABLE_BITS){1'b0}}};
      x = longint'(a[13:0]) << 2;
      case (a[15:14])
        2'd0: return cos_mag(x);
        2'd1: return -cos_mag(65536 - x);
        2'd2: return -cos_mag(x);
        default: return cos_mag(65536 - x);
      endcase
    endfunction

    function void write_reg(logic [1:0] idx, logic [19:0] val);
      case (idx)
        ttc_aeb_pkg::CFG_START_ANGLE:     start_angle = val[15:0];
        ttc_aeb_pkg::CFG_ANGLE_STEP:      angle_step = val[15:0];
        ttc_aeb_pkg::CFG_BRAKE_THRESHOLD: brake_threshold = val;
        ttc_aeb_pkg::CFG_NO_THREAT_TIME:  no_threat_time = val;
        default: ;
      endcase
    endfunction

    function void note_word(bit op, logic [15:0] spd, logic [15:0] rng, bit inval,
                            bit last);
      logic [15:0] angle;
      longint      closing;
      longint      numer;
      longint      quotient;
      logic [19:0] ttc;
      verdict_t    v;
      if (op == OP_SPEED) begin
        speed = spd;
        return;
      end
      angle = fresh_scan ? start_angle : next_angle;
      next_angle = angle + angle_step;
      fresh_scan = 1'b0;
      closing = longint'($signed(speed)) * cosine_q16(angle);
      if (inval || closing <= 0) begin
        ttc = no_threat_time;
      end else begin
        numer = longint'(rng) << 24;
        quotient = numer / closing;
        ttc = (quotient >= longint'(no_threat_time)) ? no_threat_time : quotient[19:0];
      end
      if (ttc < scan_min) scan_min = ttc;
      if (!last) return;
      v.brake = scan_min < brake_threshold;
      v.min_ttc = scan_min;
      verdicts_due = {verdicts_due, v};
      scan_min = 20'hFFFFF;
      fresh_scan = 1'b1;
    endfunction

    function void check_verdict(logic brake, logic [19:0] min_ttc);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result word: brake %0b min_ttc %0d", brake, min_ttc);
        return;
      end
      want = verdicts_due.pop_front();
      if (want.brake !== brake || want.min_ttc !== min_ttc) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected brake %0b min_ttc %0d, got brake %0b min_ttc %0d",
                   want.brake, want.min_ttc, brake, min_ttc);
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  ttc_tracker tracker;
  int         cycles = 0;
  int         words_sent = 0;
  int         hold_off_len = 0;
  bit         sink_stalls = 1'b1;
  bit         sender_gaps = 1'b1;

  ttc_emergency_brake #(
    .COS_TABLE_BITS(TABLE_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[ttc_emergency_brake] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready)
        tracker.write_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready)
        tracker.note_word(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                          s_axis_tdata[32], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        tracker.check_verdict(m_axis_tdata[0], m_axis_tdata[20:1]);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] rand_speed();
    if ($urandom_range(0, 9) < 3) return 16'($urandom());
    return 16'($urandom_range(16'h0080, 16'h2000));
  endfunction

  function automatic logic [15:0] rand_range();
    if ($urandom_range(0, 1) == 1) return 16'($urandom());
    return 16'($urandom_range(0, 16'h1000));
  endfunction

  initial begin
    int stall;
    @(posedge clk);
    forever begin
      if (hold_off_len > 0) begin
        stall = hold_off_len;
        hold_off_len = 0;
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_word(bit op, logic [15:0] spd, logic [15:0] rng, bit inval,
                           bit last);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tlast <= last;
    s_axis_tdata <= {7'd0, inval, rng, spd};
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // A speed word or an unfinished scan leaves nothing to wait for, so settle
  // also waits out a beam still in progress before the registers change.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic reconfigure();
    int r;
    r = $urandom_range(0, 5);
    write_reg(ttc_aeb_pkg::CFG_START_ANGLE, r == 0 ? 20'h08000 : r == 1 ? 20'h07FFF :
              20'($urandom_range(0, 16'hFFFF)));
    r = $urandom_range(0, 5);
    write_reg(ttc_aeb_pkg::CFG_ANGLE_STEP, r == 0 ? 20'h00000 : r == 1 ? 20'h0FFFF :
              r == 2 ? 20'($urandom_range(0, 16'hFFFF)) :
              20'($urandom_range(0, 16'h0800)));
    r = $urandom_range(0, 5);
    write_reg(ttc_aeb_pkg::CFG_BRAKE_THRESHOLD, r == 0 ? 20'h00000 : r == 1 ? 20'hFFFFF :
              r == 2 ? 20'($urandom()) : 20'($urandom_range(0, 4000)));
    r = $urandom_range(0, 6);
    write_reg(ttc_aeb_pkg::CFG_NO_THREAT_TIME, r == 0 ? 20'h00000 : r == 1 ? 20'hFFFFF :
              r == 2 ? 20'($urandom()) : r == 3 ? 20'd768000 :
              20'($urandom_range(1000, 100000)));
  endtask

  task automatic run_scan();
    int beams;
    beams = $urandom_range(1, 8);
    if ($urandom_range(0, 1) == 1)
      send_word(OP_SPEED, rand_speed(), 16'($urandom()), 1'($urandom()), 1'($urandom()));
    for (int k = 0; k < beams; k++) begin
      if ($urandom_range(0, 11) == 0)
        send_word(OP_SPEED, rand_speed(), 16'($urandom()), 1'($urandom()), 1'b0);
      send_word(OP_BEAM, 16'($urandom()), rand_range(), $urandom_range(0, 9) == 0,
                k == beams - 1);
    end
  endtask

  task automatic send_noise();
    int beams;
    if ($urandom_range(0, 1) == 1) begin
      send_word(1'($urandom()), 16'($urandom()), 16'($urandom()), 1'($urandom()),
                1'($urandom()));
    end else begin
      beams = $urandom_range(1, 3);
      repeat (beams)
        send_word(OP_BEAM, 16'($urandom()), rand_range(), 1'($urandom()), 1'b0);
    end
  endtask

  initial begin
    int target;
    tracker = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(OP_SPEED, 16'h0100, 16'h0000, 1'b0, 1'b0);
    send_word(OP_BEAM, 16'h0000, 16'h0100, 1'b0, 1'b1);
    send_word(OP_BEAM, 16'h0000, 16'h0100, 1'b1, 1'b1);
    send_word(OP_SPEED, 16'h7FFF, 16'hFFFF, 1'b1, 1'b1);
    send_word(OP_BEAM, 16'hFFFF, 16'h0000, 1'b0, 1'b1);
    send_word(OP_SPEED, 16'h8000, 16'h0000, 1'b0, 1'b0);
    send_word(OP_BEAM, 16'h0000, 16'hFFFF, 1'b0, 1'b1);
    send_word(OP_SPEED, 16'h0001, 16'h0000, 1'b0, 1'b0);
    send_word(OP_BEAM, 16'h0000, 16'hFFFF, 1'b0, 1'b1);
    send_word(OP_SPEED, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_word(OP_BEAM, 16'h0000, 16'h1234, 1'b0, 1'b1);
    send_word(OP_SPEED, 16'h0A00, 16'h0000, 1'b0, 1'b0);
    send_word(OP_BEAM, 16'h0000, 16'h2000, 1'b0, 1'b0);
    send_word(OP_BEAM, 16'h0000, 16'h0500, 1'b1, 1'b0);
    send_word(OP_SPEED, 16'h1400, 16'h0000, 1'b0, 1'b0);
    send_word(OP_BEAM, 16'h0000, 16'h0800, 1'b0, 1'b1);

    settle();
    write_reg(ttc_aeb_pkg::CFG_START_ANGLE, 20'h08000);
    write_reg(ttc_aeb_pkg::CFG_ANGLE_STEP, 20'h04000);
    write_reg(ttc_aeb_pkg::CFG_BRAKE_THRESHOLD, 20'hFFFFF);
    write_reg(ttc_aeb_pkg::CFG_NO_THREAT_TIME, 20'hFFFFF);
    send_word(OP_SPEED, 16'h0200, 16'h0000, 1'b0, 1'b0);
    send_word(OP_BEAM, 16'h0000, 16'h0300, 1'b0, 1'b0);
    send_word(OP_BEAM, 16'h0000, 16'h0300, 1'b0, 1'b0);
    send_word(OP_BEAM, 16'h0000, 16'h0300, 1'b0, 1'b0);
    send_word(OP_BEAM, 16'h0000, 16'h0300, 1'b0, 1'b1);

    settle();
    write_reg(ttc_aeb_pkg::CFG_START_ANGLE, 20'h07FFF);
    write_reg(ttc_aeb_pkg::CFG_ANGLE_STEP, 20'h0FFFF);
    write_reg(ttc_aeb_pkg::CFG_BRAKE_THRESHOLD, 20'h00000);
    write_reg(ttc_aeb_pkg::CFG_NO_THREAT_TIME, 20'h00000);
    send_word(OP_BEAM, 16'h0000, 16'h4000, 1'b0, 1'b0);
    send_word(OP_BEAM, 16'h0000, 16'h0000, 1'b0, 1'b1);

    for (int ph = 0; ph < 12; ph++) begin
      settle();
      reconfigure();
      sink_stalls = $urandom_range(0, 3) != 0;
      sender_gaps = $urandom_range(0, 3) != 0;
      if (ph == 2) begin
        sender_gaps = 1'b0;
        hold_off_len = 400;
      end
      target = words_sent + 50;
      while (words_sent < target) begin
        if ($urandom_range(0, 6) != 0) run_scan();
        else send_noise();
      end
    end

    settle();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[ttc_emergency_brake] OK");
    end else begin
      $display("[ttc_emergency_brake] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/ttc_aeb_pkg.sv
hw/rtl/ttc_emergency_brake.sv
bench/tb_top.sv
